[rtl/agc_pkg.sv]
// Shared types, constants and the microcode ROM for the gain-control block.
// Used by agc_gain_smoothed; no dependencies of its own.
package agc_pkg;

	localparam int SMP_W   = 16;
	localparam int ENV_W   = 23;
	localparam int GAIN_W  = 24;
	localparam int COEF_W  = 24;
	localparam int RATE_W  = 16;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int DVD_W   = 39;   // target_amplitude << 16
	localparam int DCNT_W  = 6;
	localparam int PROD_W  = 49;
	localparam int ACC_W   = 48;
	localparam int STEP_W  = 5;

	localparam logic [ENV_W-1:0]  ENV_MAX    = 23'h7FFFFF;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFFFFFF;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd65536;
	localparam logic [ENV_W-1:0]  ENV_RESET  = 23'd2097152;
	localparam logic [DCNT_W-1:0] DIV_STEPS  = 6'd39;

	localparam logic [COEF_W-1:0] ATTACK_RESET = 24'd16753911;
	localparam logic [COEF_W-1:0] DECAY_RESET  = 24'd16777041;
	localparam logic [RATE_W-1:0] SMOOTH_RESET = 16'd6554;
	localparam logic [GAIN_W-1:0] MAXSTEP_RESET = 24'd65536;
	localparam logic [ENV_W-1:0]  TARGET_RESET = 23'd2097152;
	localparam logic [ENV_W-1:0]  MINEST_RESET = 23'd256;
	localparam logic [GAIN_W-1:0] BYPASS_RESET = 24'd65536;

	typedef enum logic [IDX_W-1:0] {
		REG_AGC_ENABLE  = 3'd0,
		REG_ATTACK_COEF = 3'd1,
		REG_DECAY_COEF  = 3'd2,
		REG_SMOOTH_RATE = 3'd3,
		REG_MAX_STEP    = 3'd4,
		REG_TARGET_AMP  = 3'd5,
		REG_MIN_EST     = 3'd6,
		REG_BYPASS_GAIN = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_DIV_RELOAD, OP_DIV_STEP, OP_RELOAD_WB, OP_MAG, OP_SEL_COEF,
		OP_MUL_ENV, OP_MUL_MAG, OP_ACC_ADD, OP_ENV_WB, OP_DIV_TG, OP_TG_WB,
		OP_DIFF, OP_CLAMP, OP_MUL_STEP, OP_RND_STEP, OP_GAIN_UPD, OP_BYPASS,
		OP_MUL_OUT, OP_RND_OUT, OP_OUT_WR
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE, COND_ALWAYS, COND_NO_IN, COND_NO_RESTART, COND_AGC_OFF,
		COND_DIV_MORE, COND_OUT_BUSY
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic  take_in;
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	localparam step_t STEP_IDLE        = 5'd0;
	localparam step_t STEP_CHK_RST     = 5'd1;
	localparam step_t STEP_DIV_RELOAD  = 5'd2;
	localparam step_t STEP_RELOAD_LOOP = 5'd3;
	localparam step_t STEP_RELOAD_WB   = 5'd4;
	localparam step_t STEP_MAG         = 5'd5;
	localparam step_t STEP_SEL_COEF    = 5'd6;
	localparam step_t STEP_MUL_ENV     = 5'd7;
	localparam step_t STEP_MUL_MAG     = 5'd8;
	localparam step_t STEP_ACC_ADD     = 5'd9;
	localparam step_t STEP_ENV_WB      = 5'd10;
	localparam step_t STEP_DIV_TG      = 5'd11;
	localparam step_t STEP_TG_LOOP     = 5'd12;
	localparam step_t STEP_TG_WB       = 5'd13;
	localparam step_t STEP_DIFF        = 5'd14;
	localparam step_t STEP_CLAMP       = 5'd15;
	localparam step_t STEP_MUL_STEP    = 5'd16;
	localparam step_t STEP_RND_STEP    = 5'd17;
	localparam step_t STEP_GAIN_UPD    = 5'd18;
	localparam step_t STEP_BYPASS      = 5'd19;
	localparam step_t STEP_MUL_OUT     = 5'd20;
	localparam step_t STEP_RND_OUT     = 5'd21;
	localparam step_t STEP_WAIT_OUT    = 5'd22;
	localparam step_t STEP_OUT_WR      = 5'd23;

	function automatic ctrl_word_t cw_make(logic ti, op_t op, cond_t c, step_t t);
		ctrl_word_t w;
		w.take_in = ti;
		w.op      = op;
		w.cond    = c;
		w.target  = t;
		return w;
	endfunction

	// Taken jump goes to target, otherwise fall through to the next step.
	function automatic ctrl_word_t ucode_rom(step_t pc);
		ctrl_word_t w;
		case (pc)
			STEP_IDLE:        w = cw_make(1'b1, OP_NOP, COND_NO_IN, STEP_IDLE);
			STEP_CHK_RST:     w = cw_make(1'b0, OP_NOP, COND_NO_RESTART, STEP_MAG);
			STEP_DIV_RELOAD:  w = cw_make(1'b0, OP_DIV_RELOAD, COND_NONE, STEP_IDLE);
			STEP_RELOAD_LOOP: w = cw_make(1'b0, OP_DIV_STEP, COND_DIV_MORE,
				STEP_RELOAD_LOOP);
			STEP_RELOAD_WB:   w = cw_make(1'b0, OP_RELOAD_WB, COND_NONE, STEP_IDLE);
			STEP_MAG:         w = cw_make(1'b0, OP_MAG, COND_AGC_OFF, STEP_BYPASS);
			STEP_SEL_COEF:    w = cw_make(1'b0, OP_SEL_COEF, COND_NONE, STEP_IDLE);
			STEP_MUL_ENV:     w = cw_make(1'b0, OP_MUL_ENV, COND_NONE, STEP_IDLE);
			STEP_MUL_MAG:     w = cw_make(1'b0, OP_MUL_MAG, COND_NONE, STEP_IDLE);
			STEP_ACC_ADD:     w = cw_make(1'b0, OP_ACC_ADD, COND_NONE, STEP_IDLE);
			STEP_ENV_WB:      w = cw_make(1'b0, OP_ENV_WB, COND_NONE, STEP_IDLE);
			STEP_DIV_TG:      w = cw_make(1'b0, OP_DIV_TG, COND_NONE, STEP_IDLE);
			STEP_TG_LOOP:     w = cw_make(1'b0, OP_DIV_STEP, COND_DIV_MORE, STEP_TG_LOOP);
			STEP_TG_WB:       w = cw_make(1'b0, OP_TG_WB, COND_NONE, STEP_IDLE);
			STEP_DIFF:        w = cw_make(1'b0, OP_DIFF, COND_NONE, STEP_IDLE);
			STEP_CLAMP:       w = cw_make(1'b0, OP_CLAMP, COND_NONE, STEP_IDLE);
			STEP_MUL_STEP:    w = cw_make(1'b0, OP_MUL_STEP, COND_NONE, STEP_IDLE);
			STEP_RND_STEP:    w = cw_make(1'b0, OP_RND_STEP, COND_NONE, STEP_IDLE);
			STEP_GAIN_UPD:    w = cw_make(1'b0, OP_GAIN_UPD, COND_ALWAYS, STEP_MUL_OUT);
			STEP_BYPASS:      w = cw_make(1'b0, OP_BYPASS, COND_NONE, STEP_IDLE);
			STEP_MUL_OUT:     w = cw_make(1'b0, OP_MUL_OUT, COND_NONE, STEP_IDLE);
			STEP_RND_OUT:     w = cw_make(1'b0, OP_RND_OUT, COND_NONE, STEP_IDLE);
			STEP_WAIT_OUT:    w = cw_make(1'b0, OP_NOP, COND_OUT_BUSY, STEP_WAIT_OUT);
			STEP_OUT_WR:      w = cw_make(1'b0, OP_OUT_WR, COND_ALWAYS, STEP_IDLE);
			default:          w = cw_make(1'b0, OP_NOP, COND_ALWAYS, STEP_IDLE);
		endcase
		return w;
	endfunction

endpackage

[rtl/agc_gain_smoothed.sv]
// Automatic gain control: attack/decay envelope, serial divider for the target
// gain, slew-limited smoothed gain. Depends on agc_pkg (microcode ROM, types).
// One word is in work at a time: a new word is taken only once the last one is written out.
// A restart word first runs the reload division; bypass (AGC off) skips to output scaling.
// The restoring divider produces one quotient bit per cycle.
// arst_n clears the sequencer, the output valid and reloads registers and state.
module agc_gain_smoothed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_in
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] sample_out, [39:16] gain_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// Configuration registers
	logic                         agc_en_q;
	logic [agc_pkg::COEF_W-1:0]   attack_q, decay_q;
	logic [agc_pkg::RATE_W-1:0]   smooth_q;
	logic [agc_pkg::GAIN_W-1:0]   max_step_q, bypass_q;
	logic [agc_pkg::ENV_W-1:0]    target_q, min_est_q;

	// Sequencer
	agc_pkg::step_t      pc_q, pc_d;
	agc_pkg::ctrl_word_t cw;
	logic                cond_hit, s_fire;

	// Persistent state
	logic [agc_pkg::ENV_W-1:0]  env_q;
	logic [agc_pkg::GAIN_W-1:0] gain_q;

	// Datapath registers
	logic [15:0]                 x_q;
	logic                        rst_q;
	logic [agc_pkg::ENV_W-1:0]   mag_q;
	logic [agc_pkg::COEF_W-1:0]  coef_q;
	logic [24:0]                 ncoef_q;
	logic [agc_pkg::PROD_W-1:0]  prod_q;
	logic [agc_pkg::ACC_W-1:0]   acc_q;
	logic [agc_pkg::GAIN_W-1:0]  tg_q, dmag_q, app_q;
	logic [25:0]                 diff_q;
	logic                        dneg_q;
	logic [24:0]                 stepm_q, ym_q;
	logic [15:0]                 out_smp_q;
	logic [agc_pkg::GAIN_W-1:0]  out_gain_q;
	logic                        m_tvalid_q;

	// Serial divider
	logic [23:0]                 rem_q, dvs_q;
	logic [agc_pkg::DVD_W-1:0]   quo_q;
	logic [agc_pkg::DCNT_W-1:0]  dcnt_q;
	logic [24:0]                 trial, trial_sub;
	logic                        trial_ge;

	// Combinational datapath
	logic [24:0]                 mul_a;
	logic [23:0]                 mul_b;
	logic [agc_pkg::PROD_W-1:0]  prod_d;
	logic [16:0]                 xabs;
	logic [24:0]                 mag_full;
	logic [agc_pkg::ENV_W-1:0]   mag_sat, env_sat, env_floor, reload_env;
	logic [agc_pkg::COEF_W-1:0]  coef_sel;
	logic [23:0]                 env_raw;
	logic [agc_pkg::GAIN_W-1:0]  tg_sat, dmag_d, gain_new;
	logic [25:0]                 diff_d, diff_abs;
	logic [40:0]                 rnd_sum;
	logic [26:0]                 g_up, g_dn;
	logic [15:0]                 y_sat;

	//------------------------------------------------------------------
	// Configuration writes; indexes are fully decoded by the 3-bit port
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agc_en_q   <= 1'b1;
			attack_q   <= agc_pkg::ATTACK_RESET;
			decay_q    <= agc_pkg::DECAY_RESET;
			smooth_q   <= agc_pkg::SMOOTH_RESET;
			max_step_q <= agc_pkg::MAXSTEP_RESET;
			target_q   <= agc_pkg::TARGET_RESET;
			min_est_q  <= agc_pkg::MINEST_RESET;
			bypass_q   <= agc_pkg::BYPASS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				agc_pkg::REG_AGC_ENABLE:  agc_en_q   <= cfg_data[0];
				agc_pkg::REG_ATTACK_COEF: attack_q   <= cfg_data;
				agc_pkg::REG_DECAY_COEF:  decay_q    <= cfg_data;
				agc_pkg::REG_SMOOTH_RATE: smooth_q   <= cfg_data[15:0];
				agc_pkg::REG_MAX_STEP:    max_step_q <= cfg_data;
				agc_pkg::REG_TARGET_AMP:  target_q   <= cfg_data[22:0];
				agc_pkg::REG_MIN_EST:     min_est_q  <= cfg_data[22:0];
				agc_pkg::REG_BYPASS_GAIN: bypass_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Microcode sequencer: fetch the control word, evaluate its jump
	//------------------------------------------------------------------
	assign cw       = agc_pkg::ucode_rom(pc_q);
	assign s_tready = cw.take_in;
	assign s_fire   = s_tvalid && cw.take_in;

	always_comb begin
		case (cw.cond)
			agc_pkg::COND_NONE:       cond_hit = 1'b0;
			agc_pkg::COND_ALWAYS:     cond_hit = 1'b1;
			agc_pkg::COND_NO_IN:      cond_hit = !s_fire;
			agc_pkg::COND_NO_RESTART: cond_hit = !rst_q;
			agc_pkg::COND_AGC_OFF:    cond_hit = !agc_en_q;
			// stay in the loop until the last quotient bit is being produced
			agc_pkg::COND_DIV_MORE:   cond_hit = (dcnt_q != agc_pkg::DCNT_W'(1));
			agc_pkg::COND_OUT_BUSY:   cond_hit = m_tvalid_q && !m_tready;
			default:                  cond_hit = 1'b0;
		endcase
	end

	assign pc_d = cond_hit ? cw.target : pc_q + agc_pkg::STEP_W'(1);

	//------------------------------------------------------------------
	// Restoring divider step: one quotient bit per cycle
	//------------------------------------------------------------------
	assign trial     = {rem_q, quo_q[agc_pkg::DVD_W-1]};
	assign trial_ge  = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	//------------------------------------------------------------------
	// Shared multiplier, operands chosen by the current op
	//------------------------------------------------------------------
	assign xabs = x_q[15] ? 17'd0 - {x_q[15], x_q} : {1'b0, x_q};

	always_comb begin
		case (cw.op)
			agc_pkg::OP_MUL_ENV: begin
				mul_a = {1'b0, coef_q};
				mul_b = {1'b0, env_q};
			end
			agc_pkg::OP_MUL_MAG: begin
				mul_a = ncoef_q;
				mul_b = {1'b0, mag_q};
			end
			agc_pkg::OP_MUL_STEP: begin
				mul_a = {1'b0, dmag_q};
				mul_b = {8'd0, smooth_q};
			end
			agc_pkg::OP_MUL_OUT: begin
				mul_a = {8'd0, xabs};
				mul_b = app_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = {24'd0, mul_a} * {25'd0, mul_b};

	// |x| in Q15.8, most negative sample saturates
	assign mag_full = {xabs, 8'd0};
	assign mag_sat  = (mag_full > {2'b0, agc_pkg::ENV_MAX}) ? agc_pkg::ENV_MAX
		: mag_full[22:0];

	// Attack pole when the input rises above the envelope
	assign coef_sel = (mag_q > env_q) ? attack_q : decay_q;

	// Envelope write-back: saturate, then floor at the minimum estimate
	assign env_raw   = acc_q[47:24];
	assign env_sat   = (env_raw > {1'b0, agc_pkg::ENV_MAX}) ? agc_pkg::ENV_MAX
		: env_raw[22:0];
	assign env_floor = (env_sat < min_est_q) ? min_est_q : env_sat;

	// Quotient saturation; a zero divisor yields all ones and saturates too
	assign reload_env = (quo_q > {16'd0, agc_pkg::ENV_MAX}) ? agc_pkg::ENV_MAX
		: quo_q[22:0];
	assign tg_sat     = (quo_q > {15'd0, agc_pkg::GAIN_MAX}) ? agc_pkg::GAIN_MAX
		: quo_q[23:0];

	// Gain delta clamped to +-max_gain_step, kept as sign and magnitude
	assign diff_d   = {2'b0, tg_q} - {2'b0, gain_q};
	assign diff_abs = diff_q[25] ? 26'd0 - diff_q : diff_q;
	assign dmag_d   = (diff_abs > {2'b0, max_step_q}) ? max_step_q : diff_abs[23:0];

	// Round half away from zero on the magnitude
	assign rnd_sum = {1'b0, prod_q[39:0]} + 41'd32768;

	// Gain update with clamp to 0..GAIN_MAX
	assign g_up = {3'b0, gain_q} + {2'b0, stepm_q};
	assign g_dn = {3'b0, gain_q} - {2'b0, stepm_q};
	always_comb begin
		if (dneg_q)
			gain_new = g_dn[26] ? '0 : g_dn[23:0];
		else
			gain_new = (g_up > {3'b0, agc_pkg::GAIN_MAX}) ? agc_pkg::GAIN_MAX
				: g_up[23:0];
	end

	// Output saturation to 16 bits
	always_comb begin
		if (x_q[15])
			y_sat = (ym_q > 25'd32768) ? 16'h8000 : 16'd0 - ym_q[15:0];
		else
			y_sat = (ym_q > 25'd32767) ? 16'h7FFF : ym_q[15:0];
	end

	//------------------------------------------------------------------
	// Control and state registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= agc_pkg::STEP_IDLE;
			m_tvalid_q <= 1'b0;
			dcnt_q     <= '0;
			env_q      <= agc_pkg::ENV_RESET;
			gain_q     <= agc_pkg::UNITY_GAIN;
		end else begin
			pc_q <= pc_d;
			// set on write; the wait step guarantees the slot is free
			if (cw.op == agc_pkg::OP_OUT_WR)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (cw.op)
				agc_pkg::OP_DIV_RELOAD, agc_pkg::OP_DIV_TG: dcnt_q <= agc_pkg::DIV_STEPS;
				agc_pkg::OP_DIV_STEP: dcnt_q <= dcnt_q - agc_pkg::DCNT_W'(1);
				agc_pkg::OP_RELOAD_WB: begin
					env_q  <= reload_env;
					gain_q <= agc_pkg::UNITY_GAIN;
				end
				agc_pkg::OP_ENV_WB:   env_q  <= env_floor;
				agc_pkg::OP_GAIN_UPD: gain_q <= gain_new;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Datapath payload registers
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// hold the accepted word for the whole program
		if (s_fire) begin
			x_q   <= s_tdata;
			rst_q <= s_tuser;
		end
		case (cw.op)
			agc_pkg::OP_DIV_RELOAD: begin
				rem_q <= '0;
				quo_q <= {target_q, 16'd0};
				dvs_q <= bypass_q;
			end
			agc_pkg::OP_DIV_TG: begin
				rem_q <= '0;
				quo_q <= {target_q, 16'd0};
				dvs_q <= {1'b0, env_q};
			end
			agc_pkg::OP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_sub[23:0] : trial[23:0];
				quo_q <= {quo_q[agc_pkg::DVD_W-2:0], trial_ge};
			end
			agc_pkg::OP_MAG: mag_q <= mag_sat;
			agc_pkg::OP_SEL_COEF: begin
				coef_q  <= coef_sel;
				ncoef_q <= 25'h1000000 - {1'b0, coef_sel};
			end
			agc_pkg::OP_MUL_ENV, agc_pkg::OP_MUL_STEP, agc_pkg::OP_MUL_OUT:
				prod_q <= prod_d;
			agc_pkg::OP_MUL_MAG: begin
				// start the sum with a*env plus the rounding half
				acc_q  <= prod_q[47:0] + 48'h800000;
				prod_q <= prod_d;
			end
			agc_pkg::OP_ACC_ADD:  acc_q   <= acc_q + prod_q[47:0];
			agc_pkg::OP_TG_WB:    tg_q    <= tg_sat;
			agc_pkg::OP_DIFF:     diff_q  <= diff_d;
			agc_pkg::OP_CLAMP: begin
				dneg_q <= diff_q[25];
				dmag_q <= dmag_d;
			end
			agc_pkg::OP_RND_STEP: stepm_q <= rnd_sum[40:16];
			agc_pkg::OP_GAIN_UPD: app_q   <= gain_new;
			agc_pkg::OP_BYPASS:   app_q   <= bypass_q;
			agc_pkg::OP_RND_OUT:  ym_q    <= rnd_sum[40:16];
			agc_pkg::OP_OUT_WR: begin
				out_smp_q  <= y_sat;
				out_gain_q <= app_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_gain_q, out_smp_q};

endmodule

[rtl/agc_chk.sv]
// Port-level checker for agc_gain_smoothed, attached by the bind below.
// Uses only the top-level handshake and output data ports; no package dependency.
module agc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_hs, out_hs;

	assign in_hs  = s_tvalid && s_tready;
	assign out_hs = m_tvalid && m_tready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_hs && !out_hs)
			pend_q <= pend_q + 2'd1;
		else if (out_hs && !in_hs)
			pend_q <= pend_q - 2'd1;
	end

	// at most one word in work and one in the output register
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two words outstanding");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output word without an accepted input");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> !s_tready && !$rose(m_tvalid))
		else $error("input taken again or result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

endmodule

bind agc_gain_smoothed agc_chk u_agc_chk (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for agc_gain_smoothed: directed table, then random register phases.
// Depends on agc_pkg (register indexes, reset constants) and the agc_gain_smoothed RTL.
module tb;

	localparam longint ENV_TOP   = 64'sd8388607;
	localparam longint GAIN_TOP  = 64'sd16777215;
	localparam longint UNITY     = 64'sd65536;
	localparam int     N_PHASES  = 11;
	localparam int     PER_PHASE = 50;
	localparam int     N_DIR     = 37;

	// One output word: scaled sample and the gain applied to it.
	typedef struct packed {
		logic signed [15:0] smp;
		logic [23:0]        gain;
	} gain_result_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// Directed row: either an input word or a register write.
	typedef struct packed {
		row_kind_t         kind;
		agc_pkg::reg_idx_t reg_sel;
		logic [23:0]       val;       // register value, or sample in [15:0]
		logic              restart;
		logic              typed;     // use the hand-written result below
		gain_result_t      want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] sample_in
	logic        s_tuser = 1'b0; // [0] restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [15:0] sample_out, [39:16] gain_out
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// Predictor copy of the registers and the filter state.
	longint r_enable = 1;
	longint r_attack = agc_pkg::ATTACK_RESET;
	longint r_decay  = agc_pkg::DECAY_RESET;
	longint r_smooth = agc_pkg::SMOOTH_RESET;
	longint r_step   = agc_pkg::MAXSTEP_RESET;
	longint r_target = agc_pkg::TARGET_RESET;
	longint r_floor  = agc_pkg::MINEST_RESET;
	longint r_bypass = agc_pkg::BYPASS_RESET;
	longint env_est  = agc_pkg::ENV_RESET;
	longint gain_now = agc_pkg::UNITY_GAIN;

	gain_result_t expected_words[$];
	stim_row_t    dir_rows [N_DIR];
	int mismatches = 0;
	int words_sent = 0;
	int words_seen = 0;
	int restarts = 0;
	int sat_count = 0;
	int settings = 1;
	int hold_cycles = 0;
	int send_calm = 0;
	int recv_calm = 0;

	agc_gain_smoothed dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Divide by 2^k, nearest, ties away from zero.
	function automatic longint half_away(longint v, int k);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (k - 1))) >>> k;
		return (v < 0) ? -m : m;
	endfunction

	// Advance the envelope and the smoothed gain by one sample, return the output word.
	function automatic gain_result_t agc_predict(logic signed [15:0] smp, logic restart);
		longint x, mag, coef, env_n, tgt, delta, g, y, gain;
		gain_result_t r;
		x = smp;
		if (restart) begin
			// Reload: envelope from target over bypass gain, unity gain.
			env_est = (r_bypass == 0) ? ENV_TOP : (r_target <<< 16) / r_bypass;
			if (env_est > ENV_TOP)
				env_est = ENV_TOP;
			gain_now = UNITY;
		end
		if (r_enable == 0) begin
			gain = r_bypass;
		end else begin
			mag = ((x < 0) ? -x : x) <<< 8;
			if (mag > ENV_TOP)
				mag = ENV_TOP;
			coef = (mag > env_est) ? r_attack : r_decay;
			env_n = (coef * env_est + ((64'sd1 <<< 24) - coef) * mag + (64'sd1 <<< 23)) >>> 24;
			if (env_n > ENV_TOP)
				env_n = ENV_TOP;
			if (env_n < r_floor)
				env_n = r_floor;
			env_est = env_n;
			tgt = (env_est == 0) ? GAIN_TOP : (r_target <<< 16) / env_est;
			if (tgt > GAIN_TOP)
				tgt = GAIN_TOP;
			// Slew-limit the move toward the target, then scale it by the rate.
			delta = tgt - gain_now;
			if (delta > r_step)
				delta = r_step;
			else if (delta < -r_step)
				delta = -r_step;
			g = gain_now + half_away(delta * r_smooth, 16);
			if (g < 0)
				g = 0;
			if (g > GAIN_TOP)
				g = GAIN_TOP;
			gain_now = g;
			gain = g;
		end
		y = half_away(x * gain, 16);
		if (y > 32767) begin
			y = 32767;
			sat_count++;
		end else if (y < -32768) begin
			y = -32768;
			sat_count++;
		end
		r.smp = y[15:0];
		r.gain = gain[23:0];
		return r;
	endfunction

	// Zero-gap stretches come now and then; otherwise the gap is drawn at random.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(8, 30);
		return $urandom_range(0, 19);
	endfunction

	// Mostly plausible values, sometimes an extreme of the register.
	function automatic logic [23:0] pick_value(logic [23:0] top, int lo, int hi);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return top;
			default: return 24'($urandom_range(lo, hi));
		endcase
	endfunction

	// Offer one word after a random gap; predict once it is taken.
	task automatic send_word(input logic [15:0] smp, input logic restart, input logic typed,
			input gain_result_t want);
		int gap;
		gain_result_t r;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		r = agc_predict(smp, restart);
		expected_words.push_back(typed ? want : r);
		words_sent++;
		if (restart)
			restarts++;
	endtask

	// Hold the input idle until every predicted word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	task automatic set_reg(input agc_pkg::reg_idx_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			agc_pkg::REG_AGC_ENABLE:  r_enable = val[0];
			agc_pkg::REG_ATTACK_COEF: r_attack = val;
			agc_pkg::REG_DECAY_COEF:  r_decay = val;
			agc_pkg::REG_SMOOTH_RATE: r_smooth = val[15:0];
			agc_pkg::REG_MAX_STEP:    r_step = val;
			agc_pkg::REG_TARGET_AMP:  r_target = val[22:0];
			agc_pkg::REG_MIN_EST:     r_floor = val[22:0];
			agc_pkg::REG_BYPASS_GAIN: r_bypass = val;
			default: ;
		endcase
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin : result_side
		int gap;
		wait (arst_n);
		forever begin
			gap = draw_gap(recv_calm);
			if (hold_cycles > 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare every taken output word against the oldest prediction.
	always @(posedge clk) begin : check_words
		gain_result_t want;
		gain_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.smp = m_tdata[15:0];
			got.gain = m_tdata[39:16];
			words_seen++;
			if (expected_words.size() == 0) begin
				$error("unexpected output word: sample_out %0d gain_out %0d",
					$signed(got.smp), got.gain);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (got.smp !== want.smp) begin
					$error("sample_out: expected %0d, actual %0d",
						$signed(want.smp), $signed(got.smp));
					mismatches++;
				end
				if (got.gain !== want.gain) begin
					$error("gain_out: expected %0d, actual %0d", want.gain, got.gain);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [23:0] cfg_vals [8];
		logic [15:0] smp;
		logic        rst;
		int amp, s, level_left;
		dir_rows = '{
			// After reset, silence: envelope barely moves, gain stays unity; then loud words and a restart.
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0000, 1'b0, 1'b1, '{16'h0000, 24'd65536}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b1, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h3039, 1'b0, 1'b0, '0},
			// Bypass at unity: words pass through untouched.
			'{ROW_REG,  agc_pkg::REG_AGC_ENABLE, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b0, 1'b1, '{16'h7FFF, 24'd65536}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b0, 1'b1, '{16'h8000, 24'd65536}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 24'd65536}},
			// Largest bypass gain: saturate both ways, small input scales by 256.
			'{ROW_REG,  agc_pkg::REG_BYPASS_GAIN, 24'hFFFFFF, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b1, 1'b1, '{16'h7FFF, 24'hFFFFFF}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b0, 1'b1, '{16'h8000, 24'hFFFFFF}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0001, 1'b0, 1'b1, '{16'h0100, 24'hFFFFFF}},
			// Smallest gain: half-way ties round away from zero.
			'{ROW_REG,  agc_pkg::REG_BYPASS_GAIN, 24'h000001, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b0, 1'b1, '{16'hFFFF, 24'd1}},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b0, 1'b1, '{16'h0000, 24'd1}},
			// Zero bypass gain on restart: envelope saturates, output is zero.
			'{ROW_REG,  agc_pkg::REG_BYPASS_GAIN, 24'h000000, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h03E8, 1'b1, 1'b1, '{16'h0000, 24'd0}},
			'{ROW_REG,  agc_pkg::REG_AGC_ENABLE, 24'h1, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0000, 1'b0, 1'b0, '0},
			// No floor and zero poles: envelope can reach zero, target saturates.
			'{ROW_REG,  agc_pkg::REG_MIN_EST, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_DECAY_COEF, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_ATTACK_COEF, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0000, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_SMOOTH_RATE, 24'hFFFF, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_MAX_STEP, 24'hFFFFFF, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0000, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h7FFF, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h8000, 1'b0, 1'b0, '0},
			// Zero target drives the gain down toward zero.
			'{ROW_REG,  agc_pkg::REG_TARGET_AMP, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h0064, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'hFFFB, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_TARGET_AMP, 24'h7FFFFF, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_SMOOTH_RATE, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_REG,  agc_pkg::REG_MAX_STEP, 24'h0, 1'b0, 1'b0, '0},
			'{ROW_WORD, agc_pkg::REG_AGC_ENABLE, 24'h022B, 1'b1, 1'b0, '0}
		};
		level_left = 0;
		amp = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain();
				set_reg(dir_rows[i].reg_sel, dir_rows[i].val);
				settings++;
			end else begin
				send_word(dir_rows[i].val[15:0], dir_rows[i].restart, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		// Random phases: rewrite every register while idle, then stream words.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				cfg_vals = '{24'd1, agc_pkg::ATTACK_RESET, agc_pkg::DECAY_RESET,
					24'(agc_pkg::SMOOTH_RESET), agc_pkg::MAXSTEP_RESET,
					24'(agc_pkg::TARGET_RESET), 24'(agc_pkg::MINEST_RESET),
					agc_pkg::BYPASS_RESET};
			end else begin
				cfg_vals[0] = (ph % 3 == 2) ? 24'd0 : 24'd1;
				cfg_vals[1] = pick_value(24'hFFFFFF, 16577215, 16777215);
				cfg_vals[2] = pick_value(24'hFFFFFF, 16775215, 16777215);
				cfg_vals[3] = pick_value(24'h00FFFF, 1, 65534);
				cfg_vals[4] = pick_value(24'hFFFFFF, 1, 200000);
				cfg_vals[5] = pick_value(24'h7FFFFF, 256, 4194304);
				cfg_vals[6] = pick_value(24'h7FFFFF, 1, 65536);
				cfg_vals[7] = pick_value(24'hFFFFFF, 1, 300000);
			end
			for (int i = 0; i < 8; i++)
				set_reg(agc_pkg::reg_idx_t'(i), cfg_vals[i]);
			settings++;
			// Hold the output off long enough to back the block up into its input.
			if (ph == 2)
				hold_cycles = 400;
			for (int n = 0; n < PER_PHASE; n++) begin
				// Stop offering until the block has emptied.
				if (ph == 4 && n == PER_PHASE / 2)
					drain();
				if (level_left == 0) begin
					level_left = $urandom_range(5, 30);
					case ($urandom_range(0, 3))
						0: amp = $urandom_range(0, 255);
						1: amp = $urandom_range(256, 4095);
						2: amp = $urandom_range(4096, 32768);
						default: amp = 32768;
					endcase
					rst = ($urandom_range(0, 2) == 0);
				end else begin
					rst = ($urandom_range(0, 24) == 0);
				end
				level_left--;
				if ($urandom_range(0, 9) == 0) begin
					smp = 16'($urandom);
				end else begin
					s = int'($urandom_range(0, 2 * amp)) - amp;
					if (s > 32767)
						s = 32767;
					smp = s[15:0];
				end
				send_word(smp, rst, 1'b0, '0);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("run covered %0d words (%0d restarts) over %0d register settings",
			words_sent, restarts, settings);
		$display("%0d words checked, %0d predicted outputs saturated, %0d mismatches",
			words_seen, sat_count, mismatches);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

[agc_gain_smoothed.f]
rtl/agc_pkg.sv
rtl/agc_gain_smoothed.sv
rtl/agc_chk.sv
tb/tb.sv
